// File: sv/u8dc_pkg.sv
// ----------------------------------------------------------------------------
// u8dc_pkg
// shared widths, codes, bundle types and the character class tables
// ----------------------------------------------------------------------------
package u8dc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned CpW    = 21;
  localparam int unsigned CountW = 3;
  localparam int unsigned ClassW = 2;
  localparam int unsigned MaxRes = 4;

  // sequence lengths
  localparam logic [CountW-1:0] LEN_NONE  = 3'd0;
  localparam logic [CountW-1:0] LEN_ONE   = 3'd1;
  localparam logic [CountW-1:0] LEN_TWO   = 3'd2;
  localparam logic [CountW-1:0] LEN_THREE = 3'd3;
  localparam logic [CountW-1:0] LEN_FOUR  = 3'd4;

  // character classes
  localparam logic [ClassW-1:0] CLASS_OTHER  = 2'd0;
  localparam logic [ClassW-1:0] CLASS_SPACE  = 2'd1;
  localparam logic [ClassW-1:0] CLASS_DIGIT  = 2'd2;
  localparam logic [ClassW-1:0] CLASS_LETTER = 2'd3;

  // byte pattern masks
  localparam logic [ByteW-1:0] MASK_CONT  = 8'hC0;
  localparam logic [ByteW-1:0] PAT_CONT   = 8'h80;
  localparam logic [ByteW-1:0] MASK_PAY   = 8'h3F;
  localparam logic [ByteW-1:0] MASK_LEAD2 = 8'hE0;
  localparam logic [ByteW-1:0] PAT_LEAD2  = 8'hC0;
  localparam logic [ByteW-1:0] MASK_LEAD3 = 8'hF0;
  localparam logic [ByteW-1:0] PAT_LEAD3  = 8'hE0;
  localparam logic [ByteW-1:0] MASK_LEAD4 = 8'hF8;
  localparam logic [ByteW-1:0] PAT_LEAD4  = 8'hF0;

  typedef struct packed {
    logic [CpW-1:0]    code_point;
    logic [CountW-1:0] byte_count;
  } item_t;

  // all results caused by one text byte
  typedef struct packed {
    item_t [MaxRes-1:0] items;
    logic [CountW-1:0]  num;
    logic               eot;
  } bundle_t;

  function automatic logic [ClassW-1:0] u8dc_classify(input logic [CpW-1:0] cp);
    logic [ClassW-1:0] cls;
    cls = CLASS_OTHER;
    if (cp inside {21'h20, 21'h09, 21'h0A, 21'h0B, 21'h0C, 21'h0D, 21'h00A0,
                   21'h1680, 21'h2028, 21'h2029, 21'h202F, 21'h205F, 21'h3000,
                   [21'h2000:21'h200A]}) begin
      cls = CLASS_SPACE;
    end else if (cp inside {[21'h30:21'h39], [21'hFF10:21'hFF19]}) begin
      cls = CLASS_DIGIT;
    end else if (cp inside {[21'h61:21'h7A], [21'h41:21'h5A], [21'h00AA:21'h02AF],
                            [21'h0370:21'h04FF], [21'h0590:21'h08FF],
                            [21'h0900:21'h0DFF], [21'h1E00:21'h1EFF],
                            [21'h3040:21'h30FF], [21'h3400:21'h9FFF],
                            [21'hAC00:21'hD7A3], [21'hF900:21'hFAFF]}) begin
      cls = CLASS_LETTER;
    end
    return cls;
  endfunction

endpackage

// File: sv/u8dc_if.sv
// ----------------------------------------------------------------------------
// u8dc interfaces
// valid/ready channels for text bytes and decoded results
// ----------------------------------------------------------------------------
interface u8dc_byte_if;
  import u8dc_pkg::*;

  logic             valid;
  logic             ready;
  logic [ByteW-1:0] text_byte;
  logic             end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface u8dc_result_if;
  import u8dc_pkg::*;

  logic              valid;
  logic              ready;
  logic [CpW-1:0]    code_point;
  logic [CountW-1:0] byte_count;
  logic [ClassW-1:0] char_class;
  logic              run_last;
  logic              text_done;

  modport source (output valid, output code_point, output byte_count, output char_class,
                  output run_last, output text_done, input ready);
  modport sink   (input valid, input code_point, input byte_count, input char_class,
                  input run_last, input text_done, output ready);
endinterface

// File: sv/u8dc_front.sv
// ----------------------------------------------------------------------------
// u8dc_front
// accepts text bytes, tracks the pending sequence, builds result bundles
// ----------------------------------------------------------------------------
module u8dc_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  u8dc_byte_if.sink         text_i,
  input  logic              q_full_i,
  output logic              push_o,
  output u8dc_pkg::bundle_t push_data_o
);
  import u8dc_pkg::*;

  logic [ByteW-1:0]  lead_q, lead_d;
  logic [CountW-1:0] len_q, len_d;
  logic [1:0]        held_q, held_d;
  logic [5:0]        pay_q [2];
  logic              pay_wr;
  logic              do_start;
  logic              accept;
  logic [CountW-1:0] n;
  logic [CpW-1:0]    cp;
  logic [5:0]        pay_now [2];
  logic [ByteW-1:0]  b;

  assign b           = text_i.text_byte;
  assign text_i.ready = !q_full_i;
  assign accept      = text_i.valid && text_i.ready;

  always_comb begin
    n              = LEN_NONE;
    push_data_o    = '0;
    lead_d         = lead_q;
    len_d          = len_q;
    held_d         = held_q;
    pay_wr         = 1'b0;
    do_start       = 1'b0;
    cp             = '0;
    pay_now[0]     = pay_q[0];
    pay_now[1]     = pay_q[1];

    if (len_q == LEN_NONE) begin
      do_start = 1'b1;
    end else if ((b & MASK_CONT) != PAT_CONT) begin
      // broken sequence: raw lead, then raw held continuations
      push_data_o.items[n[1:0]] = '{code_point: CpW'(lead_q), byte_count: LEN_ONE};
      n = n + 3'd1;
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < held_q) begin
          push_data_o.items[n[1:0]] = '{code_point: CpW'({2'b10, pay_q[i]}),
                                        byte_count: LEN_ONE};
          n = n + 3'd1;
        end
      end
      len_d    = LEN_NONE;
      held_d   = '0;
      do_start = 1'b1;
    end else if ({1'b0, held_q} + 3'd2 < len_q) begin
      pay_wr = 1'b1;
      held_d = held_q + 2'd1;
      pay_now[held_q[0]] = b[5:0];
    end else begin
      // byte completes the sequence
      case (len_q)
        LEN_TWO:   cp = CpW'({lead_q[4:0], b[5:0]});
        LEN_THREE: cp = CpW'({lead_q[3:0], pay_q[0], b[5:0]});
        LEN_FOUR:  cp = {lead_q[2:0], pay_q[0], pay_q[1], b[5:0]};
        default:   cp = '0;
      endcase
      push_data_o.items[n[1:0]] = '{code_point: cp, byte_count: len_q};
      n      = n + 3'd1;
      len_d  = LEN_NONE;
      held_d = '0;
    end

    if (do_start) begin
      if (!b[7]) begin
        push_data_o.items[n[1:0]] = '{code_point: CpW'(b), byte_count: LEN_ONE};
        n = n + 3'd1;
      end else if ((b & MASK_LEAD2) == PAT_LEAD2) begin
        lead_d = b;
        len_d  = LEN_TWO;
        held_d = '0;
      end else if ((b & MASK_LEAD3) == PAT_LEAD3) begin
        lead_d = b;
        len_d  = LEN_THREE;
        held_d = '0;
      end else if ((b & MASK_LEAD4) == PAT_LEAD4) begin
        lead_d = b;
        len_d  = LEN_FOUR;
        held_d = '0;
      end else begin
        push_data_o.items[n[1:0]] = '{code_point: CpW'(b), byte_count: LEN_ONE};
        n = n + 3'd1;
      end
    end

    // end of text flushes whatever is still pending
    if (text_i.end_of_text && (len_d != LEN_NONE)) begin
      push_data_o.items[n[1:0]] = '{code_point: CpW'(lead_d), byte_count: LEN_ONE};
      n = n + 3'd1;
      for (int i = 0; i < 2; i++) begin
        if (2'(i) < held_d) begin
          push_data_o.items[n[1:0]] = '{code_point: CpW'({2'b10, pay_now[i]}),
                                        byte_count: LEN_ONE};
          n = n + 3'd1;
        end
      end
      len_d  = LEN_NONE;
      held_d = '0;
    end

    push_data_o.num = n;
    push_data_o.eot = text_i.end_of_text;
  end

  assign push_o = accept && (n != LEN_NONE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lead_q <= '0;
      len_q  <= LEN_NONE;
      held_q <= '0;
    end else if (accept) begin
      lead_q <= lead_d;
      len_q  <= len_d;
      held_q <= held_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && pay_wr) begin
      pay_q[held_q[0]] <= b[5:0];
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q == LEN_NONE) |-> (held_q == 2'd0))
    else $error("continuations held with no sequence pending");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (len_q != LEN_NONE) |-> ({1'b0, held_q} + 3'd2 <= len_q))
    else $error("held continuation count exceeds sequence length");

endmodule

// File: sv/u8dc_queue.sv
// ----------------------------------------------------------------------------
// u8dc_queue
// two-entry bundle queue between the front and back parts
// ----------------------------------------------------------------------------
module u8dc_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  u8dc_pkg::bundle_t push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              head_valid_o,
  output u8dc_pkg::bundle_t head_o
);
  import u8dc_pkg::*;

  bundle_t    mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] cnt_q;

  assign full_o       = (cnt_q == 2'd2);
  assign head_valid_o = (cnt_q != 2'd0);
  assign head_o       = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      if (push_i) wr_ptr_q <= !wr_ptr_q;
      if (pop_i)  rd_ptr_q <= !rd_ptr_q;
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 2'd1;
        2'b01:   cnt_q <= cnt_q - 2'd1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && full_o) && !(pop_i && !head_valid_o))
    else $error("queue overflow or underflow");

endmodule

// File: sv/u8dc_back.sv
// ----------------------------------------------------------------------------
// u8dc_back
// walks each bundle one result per cycle while the output is taken, classifies, registers the output
// ----------------------------------------------------------------------------
module u8dc_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  u8dc_pkg::bundle_t head_i,
  output logic              pop_o,
  u8dc_result_if.source     result_o
);
  import u8dc_pkg::*;

  logic [1:0]        idx_q;
  logic              out_valid_q;
  logic [CpW-1:0]    cp_q;
  logic [CountW-1:0] cnt_q;
  logic [ClassW-1:0] cls_q;
  logic              last_q, done_q;
  logic              advance, load, is_last;
  item_t             cur;

  assign cur     = head_i.items[idx_q];
  assign is_last = ({1'b0, idx_q} + 3'd1 == head_i.num);
  assign advance = !out_valid_q || result_o.ready;
  assign load    = advance && head_valid_i;
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (advance) out_valid_q <= head_valid_i;
      if (load)    idx_q       <= is_last ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      cp_q   <= cur.code_point;
      cnt_q  <= cur.byte_count;
      cls_q  <= u8dc_classify(cur.code_point);
      last_q <= is_last;
      done_q <= is_last && head_i.eot;
    end
  end

  assign result_o.valid      = out_valid_q;
  assign result_o.code_point = cp_q;
  assign result_o.byte_count = cnt_q;
  assign result_o.char_class = cls_q;
  assign result_o.run_last   = last_q;
  assign result_o.text_done  = done_q;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    head_valid_i |-> ({1'b0, idx_q} < head_i.num))
    else $error("result index beyond bundle size");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && done_q) |-> last_q)
    else $error("text done on a result that is not last of its byte");

endmodule

// File: sv/utf8_decode_and_classify.sv
// ----------------------------------------------------------------------------
// utf8_decode_and_classify
// streaming utf-8 decoder with per code point character class
// ----------------------------------------------------------------------------
// The block takes one text byte per cycle on text_i and returns decoded code
// points on result_o, each with its byte count, a class (other, whitespace,
// digit, letter), a run_last flag on the last result of each byte and a
// text_done flag on the final result of a byte marked end_of_text. A byte
// causes zero to four results: a buffered lead or continuation gives none, a
// broken or cut-short sequence comes out byte by byte as raw values. Input
// bytes are taken at one per cycle while the two-entry bundle queue has room;
// results leave at one per cycle from the output register while the sink is
// ready, and the first result of a byte passes through its queue entry and
// then the output register. No overlong, surrogate or range checks are made.
// ----------------------------------------------------------------------------
module utf8_decode_and_classify (
  input  logic          clk_i,
  input  logic          rst_ni,
  u8dc_byte_if.sink     text_i,
  u8dc_result_if.source result_o
);
  import u8dc_pkg::*;

  // front to queue
  logic    push;
  bundle_t push_data;
  logic    q_full;

  // queue to back
  logic    pop;
  logic    head_valid;
  bundle_t head;

  // front: decode state and bundle builder, stalls only when the queue is full
  u8dc_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .text_i      (text_i),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  // decouples the byte side from the result side
  u8dc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_data_i  (push_data),
    .full_o       (q_full),
    .pop_i        (pop),
    .head_valid_o (head_valid),
    .head_o       (head)
  );

  // back: one result per cycle into the output register while the sink is ready
  u8dc_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .result_o     (result_o)
  );

endmodule
